@@ rtl/core/assert_macros.svh @@
// assertion helpers used by the checker file mbfr_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while in reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on the next clock after the trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

@@ rtl/core/mbfr_pkg.sv @@
package mbfr_pkg;

	// index and length width, fixed by the frame_length field
	localparam int IDX_W = 6;

	// result item kinds
	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_NACK = 2'd1;
	localparam logic [1:0] KIND_BYTE = 2'd2;

	// register select bit (byte address bit 2)
	localparam logic REG_ACK  = 1'b0;
	localparam logic REG_NACK = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       mode_bit;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] frame_length;
		logic             last;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic load_byte;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic emit_ack;
		logic emit_nack;
		logic emit_frame;
		logic out_last;
	} dp_stat_t;

endpackage

@@ rtl/core/mbfr_ram.sv @@
module mbfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 40,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ rtl/core/mbfr_ctrl.sv @@
module mbfr_ctrl import mbfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HOLD = 2'd1;
	localparam logic [1:0] ST_RD   = 2'd2;
	localparam logic [1:0] ST_LD   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt     = state_q;
		cmd.accept    = 1'b0;
		cmd.load_byte = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.emit_ack || stat.emit_nack) begin
						state_nxt = ST_HOLD;
					end else if (stat.emit_frame) begin
						state_nxt = ST_RD;
					end
				end
			end
			ST_HOLD: begin
				if (!out_stall) begin
					state_nxt = stat.out_last ? ST_IDLE : ST_RD;
				end
			end
			ST_RD: begin
				state_nxt = ST_LD;
			end
			ST_LD: begin
				cmd.load_byte = 1'b1;
				state_nxt     = ST_HOLD;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ rtl/core/mbfr_dp.sv @@
module mbfr_dp import mbfr_pkg::*; #(
	parameter int FRAME_CAPACITY = 40,
	localparam int AW = $clog2(FRAME_CAPACITY)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  in_item_t      in_item,
	input  logic [7:0]    ack_code,
	input  logic [7:0]    nack_code,
	input  dp_cmd_t       cmd,
	output dp_stat_t      stat,
	output logic          ram_we,
	output logic [AW-1:0] ram_addr,
	output logic [7:0]    ram_wdata,
	input  logic [7:0]    ram_rdata,
	output out_item_t     out_item
);

	logic [IDX_W-1:0] fill_q;
	logic [7:0]       sum_q;
	logic [IDX_W-1:0] len_q;
	logic [IDX_W-1:0] rd_idx_q;
	out_item_t        out_q;

	logic             wrap;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] wr_next;
	logic [7:0]       sum_eff;
	logic [7:0]       sum_nxt;
	logic             match;
	logic             len_nz;

	// store full: start over at entry zero, earlier bytes leave the sum
	assign wrap    = (fill_q >= IDX_W'(FRAME_CAPACITY));
	assign wr_idx  = wrap ? '0 : fill_q;
	assign wr_next = wr_idx + IDX_W'(1);
	assign sum_eff = wrap ? '0 : sum_q;
	assign sum_nxt = sum_eff + in_item.data_byte;
	assign match   = (sum_eff == in_item.data_byte);
	assign len_nz  = (wr_idx != '0);

	assign stat.emit_ack   = in_item.mode_bit && match && len_nz;
	assign stat.emit_nack  = in_item.mode_bit && !match && len_nz;
	assign stat.emit_frame = in_item.mode_bit && match;
	assign stat.out_last   = out_q.last;

	assign ram_we    = cmd.accept;
	assign ram_addr  = cmd.accept ? wr_idx[AW-1:0] : rd_idx_q[AW-1:0];
	assign ram_wdata = in_item.data_byte;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.accept) begin
			fill_q <= in_item.mode_bit ? '0 : wr_next;
			sum_q  <= in_item.mode_bit ? '0 : sum_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			len_q    <= wr_idx;
			rd_idx_q <= '0;
			if (stat.emit_ack) begin
				out_q <= '{kind: KIND_ACK, data: ack_code, frame_length: wr_next,
					last: 1'b0};
			end else if (stat.emit_nack) begin
				out_q <= '{kind: KIND_NACK, data: nack_code, frame_length: '0,
					last: 1'b1};
			end
		end else if (cmd.load_byte) begin
			out_q <= '{kind: KIND_BYTE, data: ram_rdata,
				frame_length: len_q + IDX_W'(1), last: (rd_idx_q == len_q)};
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

endmodule

@@ rtl/core/mode_bit_frame_receiver.sv @@
// receiver for 9-bit bus words (a byte plus a mode bit). data words are
// written into a frame store of FRAME_CAPACITY bytes and summed on the fly;
// the fill index wraps to zero when the store is full. a word with the mode
// bit set is the checksum word and closes the frame: on a match the block
// sends an ack item (only if the frame had earlier bytes) and then every
// stored byte, checksum included, with last set on the final one; on a
// mismatch with earlier bytes it sends one nack item (count an error). a
// lone bad checksum word gives nothing. a data word, or a checksum word
// that gives no result, is taken in the idle state and the block is ready
// again at once. while result items drain, in_stall stays high. an ack or
// nack item is held until out_stall is low; each frame byte goes through
// three steps (address, registered read of the store's single port, hold),
// the hold waiting out out_stall. the store needs no clearing pass after
// reset. ack_code sits at byte address 0, nack_code at 4.
module mode_bit_frame_receiver import mbfr_pkg::*; #(
	parameter int FRAME_CAPACITY = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// incoming bus words
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item
);

	localparam int AW = $clog2(FRAME_CAPACITY);

	// configuration registers
	logic [7:0] ack_code_q;
	logic [7:0] nack_code_q;
	logic       reg_wr;

	// controller and datapath link
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	// frame store port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;

	// register port: no wait states
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_code_q  <= 8'h00;
			nack_code_q <= 8'hFF;
		end else if (reg_wr) begin
			unique case (paddr[2])
				REG_ACK:  ack_code_q  <= pwdata[7:0];
				REG_NACK: nack_code_q <= pwdata[7:0];
				default:  ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (paddr[2])
			REG_ACK:  prdata = {24'd0, ack_code_q};
			REG_NACK: prdata = {24'd0, nack_code_q};
			default:  prdata = '0;
		endcase
	end

	// sequencer: accept word, then walk the store for the result items
	mbfr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// fill index, running sum, read index and output register
	mbfr_dp #(
		.FRAME_CAPACITY (FRAME_CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.ack_code  (ack_code_q),
		.nack_code (nack_code_q),
		.cmd       (cmd),
		.stat      (stat),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata),
		.out_item  (out_item)
	);

	// frame store, contents undefined until written
	mbfr_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

@@ rtl/core/mbfr_chk.sv @@
`include "assert_macros.svh"

module mbfr_chk import mbfr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	logic out_fire;
	logic is_nack;
	logic nack_ok;

	assign out_fire = out_valid && !out_stall;
	assign is_nack  = out_valid && (out_item.kind == KIND_NACK);
	assign nack_ok  = out_item.last && (out_item.frame_length == '0);

	// a result waiting at the output keeps the input side closed
	`ASSERT_CLK(a_out_blocks_in, out_valid |-> in_stall, "result pending while input open")

	// the final item of a run leaves the output empty
	`ASSERT_NEXT(a_last_drains, out_fire && out_item.last, !out_valid, "busy after last item")

	// nack closes its run alone and carries no length
	`ASSERT_CLK(a_nack_form, is_nack |-> nack_ok, "malformed nack item")

	// a stalled result stays offered
	`ASSERT_NEXT(a_valid_holds, out_valid && out_stall, out_valid, "valid dropped under stall")

endmodule

bind mode_bit_frame_receiver mbfr_chk u_chk (.*);

@@ bench/frame_reply_checker.sv @@
`timescale 1ns / 1ps

module frame_reply_checker import mbfr_pkg::*; #(
	parameter int FRAME_CAPACITY = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	output int          fail_count,
	output int unsigned pending
);

	logic [7:0]       frame_bytes [FRAME_CAPACITY];
	logic [IDX_W-1:0] fill_idx = '0;
	logic [7:0]       ack_reg = 8'h00;
	logic [7:0]       nack_reg = 8'hFF;
	out_item_t        expected_replies [$];
	int               fails = 0;
	int unsigned      shown = 0;
	int unsigned      waiting = 0;

	assign fail_count = fails;
	assign pending = waiting;

	// keeps counting once the printout limit is hit
	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fails++;
		if (shown < 40)
			$display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
		shown++;
	endtask

	function automatic out_item_t make_reply(input logic [1:0] k, input logic [7:0] d,
		input logic [IDX_W-1:0] len, input logic lst);
		out_item_t r;
		r.kind = k;
		r.data = d;
		r.frame_length = len;
		r.last = lst;
		return r;
	endfunction

	task automatic predict_bus_word(input in_item_t w);
		logic [IDX_W-1:0] len;
		logic [IDX_W-1:0] flen;
		logic [7:0]       sum;
		if (fill_idx >= FRAME_CAPACITY)
			fill_idx = '0;
		len = fill_idx;
		frame_bytes[len] = w.data_byte;
		if (!w.mode_bit) begin
			fill_idx = len + 1'b1;
			return;
		end
		sum = '0;
		for (int i = 0; i < len; i++)
			sum += frame_bytes[i];
		flen = len + 1'b1;
		if (sum == w.data_byte) begin
			if (len != 0)
				expected_replies.push_back(make_reply(KIND_ACK, ack_reg, flen, 1'b0));
			for (int i = 0; i <= len; i++)
				expected_replies.push_back(make_reply(KIND_BYTE, frame_bytes[i], flen,
					i == len));
		end else if (len != 0) begin
			expected_replies.push_back(make_reply(KIND_NACK, nack_reg, '0, 1'b1));
		end
		fill_idx = '0;
	endtask

	task automatic check_reply(input out_item_t got);
		out_item_t want;
		if (expected_replies.size() == 0) begin
			report_mismatch("unexpected result item", 32'(got), '0);
			return;
		end
		want = expected_replies.pop_front();
		if (got.kind !== want.kind)
			report_mismatch("kind", 32'(got.kind), 32'(want.kind));
		if (got.data !== want.data)
			report_mismatch("data", 32'(got.data), 32'(want.data));
		if (got.frame_length !== want.frame_length)
			report_mismatch("frame_length", 32'(got.frame_length),
				32'(want.frame_length));
		if (got.last !== want.last)
			report_mismatch("last", 32'(got.last), 32'(want.last));
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			fill_idx = '0;
			ack_reg = 8'h00;
			nack_reg = 8'hFF;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_ACK)
						ack_reg = pwdata[7:0];
					else
						nack_reg = pwdata[7:0];
				end else if (prdata[7:0] !== ((paddr[2] == REG_ACK) ? ack_reg : nack_reg)) begin
					report_mismatch("register read", 32'(prdata[7:0]),
						32'((paddr[2] == REG_ACK) ? ack_reg : nack_reg));
				end
			end
			if (out_valid && !out_stall)
				check_reply(out_item);
			if (in_valid && !in_stall)
				predict_bus_word(in_item);
			waiting <= expected_replies.size();
		end
	end

endmodule

@@ bench/mode_bit_frame_receiver_tb.sv @@
`timescale 1ns / 1ps

module mode_bit_frame_receiver_tb;
	import mbfr_pkg::*;

	localparam int FRAME_CAPACITY = 40;
	// number of bus words from the store full cases onward, random ones included
	localparam int RANDOM_WORDS = 430;
	// register byte addresses, built from the select bit
	localparam logic [2:0] ACK_ADDR  = {REG_ACK, 2'b00};
	localparam logic [2:0] NACK_ADDR = {REG_NACK, 2'b00};

	// how the checksum word of a generated frame is picked
	typedef enum int {CHK_GOOD, CHK_BAD, CHK_RAW} chk_flavor_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;

	// random idling of the sender and stalling of the receiver
	bit          idle_on = 1'b1;
	bit          stall_on = 1'b1;
	int unsigned words_sent = 0;
	int          fail_count;
	int unsigned pending;

	always #5 clk = ~clk;

	mode_bit_frame_receiver #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	frame_reply_checker #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.fail_count(fail_count),
		.pending(pending)
	);

	// receiver back-pressure, asserted at random about a quarter of the time when enabled
	always @(posedge clk) begin
		out_stall <= stall_on && ($urandom_range(99) < 25);
	end

	// one apb transfer: setup phase, access phase held until pready, then an idle
	// step with psel low so that the next transfer never lands in the same step
	task automatic apb_transfer(input logic wr, input logic [2:0] addr,
		input logic [31:0] wdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write both codes and read them back, the checker compares the reads
	task automatic set_codes(input logic [7:0] ack, input logic [7:0] nack);
		apb_transfer(1'b1, ACK_ADDR, {24'h0, ack});
		apb_transfer(1'b1, NACK_ADDR, {24'h0, nack});
		apb_transfer(1'b0, ACK_ADDR, '0);
		apb_transfer(1'b0, NACK_ADDR, '0);
	endtask

	// hold off until every expected result item has come, then wait on so that
	// a checksum word that gave nothing is seen to stay silent
	task automatic settle();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// present one bus word and hold it until accepted; valid stays high into
	// the next call, which lowers it only if it decides to idle
	task automatic send_word(input logic [7:0] b, input logic m);
		while (idle_on && $urandom_range(99) < 25) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item.data_byte <= b;
		in_item.mode_bit <= m;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// n data words with random bytes, then the checksum word; the running sum
	// restarts where the store index wraps so a good frame still matches
	task automatic send_frame(input int n_data, input chk_flavor_t flavor);
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] chk;
		sum = '0;
		for (int i = 0; i < n_data; i++) begin
			b = 8'($urandom);
			if (i % FRAME_CAPACITY == 0)
				sum = '0;
			sum += b;
			send_word(b, 1'b0);
		end
		// exactly a full store: the checksum word wraps to index zero alone
		if (n_data > 0 && n_data % FRAME_CAPACITY == 0)
			sum = '0;
		case (flavor)
			CHK_GOOD: chk = sum;
			CHK_BAD:  chk = sum ^ 8'($urandom_range(1, 255));
			default:  chk = 8'($urandom);
		endcase
		send_word(chk, 1'b1);
	endtask

	initial begin
		int unsigned base;
		int unsigned next_phase;
		int unsigned phase;
		int unsigned pick;
		int unsigned r;
		int n;
		chk_flavor_t flavor;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// codes away from their reset values before any frame
		set_codes(8'h06, 8'h15);

		// lone checksum word of zero: one-byte frame, no ack item
		send_word(8'h00, 1'b1);
		// lone checksum words that do not match: dropped silently
		send_word(8'hFF, 1'b1);
		send_word(8'h80, 1'b1);
		// extreme bytes, good checksum
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		// bad checksum with earlier bytes: nack item
		send_word(8'h12, 1'b0);
		send_word(8'h13, 1'b1);
		// sum overflows eight bits
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFE, 1'b1);
		// short good frames
		send_word(8'h01, 1'b0);
		send_word(8'h01, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'h00, 1'b1);
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'h0F, 1'b0);
		send_word(8'h0E, 1'b1);
		// bad checksum of zero
		send_word(8'h80, 1'b0);
		send_word(8'h00, 1'b1);
		in_valid <= 1'b0;
		settle();

		set_codes(8'hFF, 8'h00);
		base = words_sent;

		// store full cases: longest frame, exact fill, and wrap past the end, good and bad
		send_frame(FRAME_CAPACITY - 1, CHK_GOOD);
		send_frame(FRAME_CAPACITY, CHK_GOOD);
		send_frame(FRAME_CAPACITY + 1, CHK_GOOD);
		send_frame(FRAME_CAPACITY + 3, CHK_BAD);

		next_phase = 100;
		phase = 0;
		while (words_sent - base < RANDOM_WORDS) begin
			// between phases: wait out every result and change the codes
			if (words_sent - base >= next_phase) begin
				in_valid <= 1'b0;
				settle();
				case (phase)
					0:       set_codes(8'h00, 8'hFF);
					1:       set_codes(8'($urandom), 8'($urandom));
					default: set_codes(8'hFF, 8'hFF);
				endcase
				phase++;
				next_phase += 100;
			end
			// a stretch with neither idling nor stalls
			idle_on = !((words_sent - base) >= 150 && (words_sent - base) < 250);
			stall_on = idle_on;

			pick = $urandom_range(99);
			if (pick < 10) begin
				// noise word
				send_word(8'($urandom), 1'($urandom_range(1)));
			end else begin
				r = $urandom_range(99);
				if (r < 8)
					n = 0;
				else if (r < 90)
					n = $urandom_range(1, 8);
				else if (r < 97)
					n = $urandom_range(9, FRAME_CAPACITY - 2);
				else
					n = $urandom_range(FRAME_CAPACITY - 1, FRAME_CAPACITY + 4);
				if (pick < 80)
					flavor = CHK_GOOD;
				else if (pick < 92)
					flavor = CHK_BAD;
				else
					flavor = CHK_RAW;
				send_frame(n, flavor);
			end
		end
		in_valid <= 1'b0;
		idle_on = 1'b1;
		stall_on = 1'b1;

		// drain, then watch a while longer for stray result items
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// guard against a hang
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
